// ===== hw/rtl/brl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants for the line rasterizer
// Coordinate widths, tile size, register map, and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package brl_pkg;

    // Tile geometry
    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int INDEX_W   = 12;
    localparam int COLOUR_W  = 32;
    // Bresenham error term, signed, covers +/- 4*TILE_SIZE
    localparam int ERR_W     = 10;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(64);

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new line command
        logic step;   // emit current pixel into output register and advance
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;   // current pixel is the final one of the line
    } t_dp_status;

    // Saturate a coordinate to the tile
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] wide;
        wide = {1'b0, v};
        if (wide < (COORD_W+1)'(TILE_SIZE)) begin
            return v;
        end
        return COORD_W'(TILE_SIZE - 1);
    endfunction

endpackage

// ===== hw/rtl/brl_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_cfg: configuration register file
// APB-style slave holding frame width and frame height; always ready.
// ----------------------------------------------------------------------------
module brl_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [brl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [brl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [brl_pkg::DIM_W-1:0]       o_frame_width,
    output logic [brl_pkg::DIM_W-1:0]       o_frame_height
);

    logic [brl_pkg::DIM_W-1:0] r_frame_width;
    logic [brl_pkg::DIM_W-1:0] r_frame_height;
    logic                      w_wr;
    logic                      w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_sel  = paddr[2];

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= brl_pkg::FRAME_WIDTH_RST;
            r_frame_height <= brl_pkg::FRAME_HEIGHT_RST;
        end else if (w_wr) begin
            if (w_sel == brl_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[brl_pkg::DIM_W-1:0];
            end else begin
                r_frame_height <= pwdata[brl_pkg::DIM_W-1:0];
            end
        end
    end

    // Read back the selected register
    always_comb begin
        prdata = '0;
        if (w_sel == brl_pkg::REG_FRAME_WIDTH) begin
            prdata[brl_pkg::DIM_W-1:0] = r_frame_width;
        end else begin
            prdata[brl_pkg::DIM_W-1:0] = r_frame_height;
        end
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;

endmodule

// ===== hw/rtl/brl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_datapath: Bresenham stepping datapath
// Orders endpoints along the major axis on load, then walks one pixel per
// step command, updating the error term and the output pixel register.
// ----------------------------------------------------------------------------
module brl_datapath (
    input  logic                          i_clk,
    input  brl_pkg::t_dp_cmd              i_cmd,
    output brl_pkg::t_dp_status           o_status,
    input  logic [brl_pkg::DIM_W-1:0]     i_frame_width,
    input  logic [brl_pkg::DIM_W-1:0]     i_frame_height,
    input  logic [brl_pkg::COORD_W-1:0]   i_start_x,
    input  logic [brl_pkg::COORD_W-1:0]   i_start_y,
    input  logic [brl_pkg::COORD_W-1:0]   i_end_x,
    input  logic [brl_pkg::COORD_W-1:0]   i_end_y,
    input  logic [brl_pkg::COLOUR_W-1:0]  i_colour,
    output logic [brl_pkg::COORD_W-1:0]   o_pixel_x,
    output logic [brl_pkg::COORD_W-1:0]   o_pixel_y,
    output logic [brl_pkg::INDEX_W-1:0]   o_pixel_index,
    output logic [brl_pkg::COLOUR_W-1:0]  o_pixel_colour,
    output logic                          o_visible,
    output logic                          o_last_pixel
);

    localparam int CW = brl_pkg::COORD_W;
    localparam int EW = brl_pkg::ERR_W;
    localparam int DW = brl_pkg::DIM_W;
    localparam int MW = CW + DW;

    // Line walk state
    logic                          r_x_major;
    logic                          r_minor_neg;
    logic [CW-1:0]                 r_major;
    logic [CW-1:0]                 r_major_end;
    logic [CW-1:0]                 r_minor;
    logic signed [EW-1:0]          r_err;
    logic signed [EW-1:0]          r_two_major;
    logic signed [EW-1:0]          r_two_minor;
    logic [brl_pkg::COLOUR_W-1:0]  r_colour;

    // Output pixel register
    logic [CW-1:0]                 r_pix_x;
    logic [CW-1:0]                 r_pix_y;
    logic [brl_pkg::INDEX_W-1:0]   r_pix_index;
    logic [brl_pkg::COLOUR_W-1:0]  r_pix_colour;
    logic                          r_pix_visible;
    logic                          r_pix_last;

    // Load-time setup signals
    logic [CW-1:0]         w_x0, w_y0, w_x1, w_y1;
    logic [CW-1:0]         w_adx, w_ady;
    logic                  w_x_major;
    logic                  w_swap;
    logic [CW-1:0]         w_maj_a, w_maj_b, w_min_a, w_min_b;
    logic [CW-1:0]         w_amaj, w_amin;
    logic signed [EW-1:0]  w_two_major, w_two_minor;

    // Step-time signals
    logic [CW-1:0]         w_cur_x, w_cur_y;
    logic [MW-1:0]         w_prod;
    logic [MW-1:0]         w_sum;
    logic                  w_last;
    logic                  w_err_pos;
    logic signed [EW-1:0]  n_err;
    logic [CW-1:0]         n_minor;

    // Clamp endpoints and pick the major axis
    always_comb begin
        w_x0 = brl_pkg::clamp_coord(i_start_x);
        w_y0 = brl_pkg::clamp_coord(i_start_y);
        w_x1 = brl_pkg::clamp_coord(i_end_x);
        w_y1 = brl_pkg::clamp_coord(i_end_y);
        w_adx = (w_x1 >= w_x0) ? (w_x1 - w_x0) : (w_x0 - w_x1);
        w_ady = (w_y1 >= w_y0) ? (w_y1 - w_y0) : (w_y0 - w_y1);
        w_x_major = (w_adx > w_ady);
        if (w_x_major) begin
            w_maj_a = w_x0;
            w_maj_b = w_x1;
            w_min_a = w_y0;
            w_min_b = w_y1;
            w_amaj  = w_adx;
            w_amin  = w_ady;
        end else begin
            w_maj_a = w_y0;
            w_maj_b = w_y1;
            w_min_a = w_x0;
            w_min_b = w_x1;
            w_amaj  = w_ady;
            w_amin  = w_adx;
        end
        w_swap = (w_maj_a > w_maj_b);
        w_two_major = EW'({w_amaj, 1'b0});
        w_two_minor = EW'({w_amin, 1'b0});
    end

    // Current pixel and its frame index
    assign w_cur_x   = r_x_major ? r_major : r_minor;
    assign w_cur_y   = r_x_major ? r_minor : r_major;
    assign w_prod    = MW'(w_cur_y) * MW'(i_frame_width);
    assign w_sum     = w_prod + MW'(w_cur_x);
    assign w_last    = (r_major == r_major_end);
    assign w_err_pos = (r_err > 0);

    // Advance the error term and the minor axis
    always_comb begin
        n_err   = r_err + r_two_minor;
        n_minor = r_minor;
        if (w_err_pos) begin
            n_err   = r_err + r_two_minor - r_two_major;
            n_minor = r_minor_neg ? (r_minor - 1'b1) : (r_minor + 1'b1);
        end
    end

    // Load a command or step the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_major   <= w_x_major;
            r_major     <= w_swap ? w_maj_b : w_maj_a;
            r_major_end <= w_swap ? w_maj_a : w_maj_b;
            r_minor     <= w_swap ? w_min_b : w_min_a;
            r_minor_neg <= w_swap ? (w_min_a < w_min_b) : (w_min_b < w_min_a);
            r_err       <= w_two_minor - EW'(w_amaj);
            r_two_major <= w_two_major;
            r_two_minor <= w_two_minor;
            r_colour    <= i_colour;
        end else if (i_cmd.step) begin
            r_major <= r_major + 1'b1;
            r_minor <= n_minor;
            r_err   <= n_err;
        end
    end

    // Capture the emitted pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pix_x       <= w_cur_x;
            r_pix_y       <= w_cur_y;
            r_pix_index   <= w_sum[brl_pkg::INDEX_W-1:0];
            r_pix_colour  <= r_colour;
            r_pix_visible <= (DW'(w_cur_x) < i_frame_width) &&
                             (DW'(w_cur_y) < i_frame_height);
            r_pix_last    <= w_last;
        end
    end

    assign o_status.last  = w_last;
    assign o_pixel_x      = r_pix_x;
    assign o_pixel_y      = r_pix_y;
    assign o_pixel_index  = r_pix_index;
    assign o_pixel_colour = r_pix_colour;
    assign o_visible      = r_pix_visible;
    assign o_last_pixel   = r_pix_last;

endmodule

// ===== hw/rtl/brl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_ctrl: rasterizer controller
// Accepts line commands when idle, issues one step per free output slot,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module brl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output brl_pkg::t_dp_cmd     o_cmd,
    input  brl_pkg::t_dp_status  i_status
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.step = (r_state == ST_RUN) && w_out_free;
    assign o_valid    = r_out_valid;

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (i_status.last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: line command to pixel stream
// Top level joining configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one line command: two endpoints
//   and a colour. o_ready is high only while no line is being walked.
//   Output channel (o_valid / i_ready) delivers one pixel per transaction,
//   with o_last_pixel set on the final pixel of the line.
//   A taken command is loaded into the walk registers, and its first pixel
//   then steps into the output register. Throughput: one pixel per cycle
//   while the receiver is ready; a line of N pixels (N = 1 + max(|dx|,
//   |dy|), at most 64) is walked in full before the next command is taken.
//   The last pixel sits in the output register while the next command is
//   accepted.
//   When the receiver stalls, the output register holds its pixel and the
//   walk pauses; nothing is dropped.
//   Reset (i_rst_n low, synchronous) returns to idle, drops any pending
//   pixel and sets frame width and height to 64.
//   Registers: frame_width at byte 0, frame_height at byte 4; write only
//   while the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [brl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [brl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // line command channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [brl_pkg::COORD_W-1:0]     i_start_x,
    input  logic [brl_pkg::COORD_W-1:0]     i_start_y,
    input  logic [brl_pkg::COORD_W-1:0]     i_end_x,
    input  logic [brl_pkg::COORD_W-1:0]     i_end_y,
    input  logic [brl_pkg::COLOUR_W-1:0]    i_colour,
    // pixel channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [brl_pkg::COORD_W-1:0]     o_pixel_x,
    output logic [brl_pkg::COORD_W-1:0]     o_pixel_y,
    output logic [brl_pkg::INDEX_W-1:0]     o_pixel_index,
    output logic [brl_pkg::COLOUR_W-1:0]    o_pixel_colour,
    output logic                            o_visible,
    output logic                            o_last_pixel
);

    logic [brl_pkg::DIM_W-1:0] w_frame_width;
    logic [brl_pkg::DIM_W-1:0] w_frame_height;
    brl_pkg::t_dp_cmd          w_cmd;
    brl_pkg::t_dp_status       w_status;

    // Configuration registers
    brl_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_frame_width  (w_frame_width),
        .o_frame_height (w_frame_height)
    );

    // Sequencing
    brl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // Line walk
    brl_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_frame_width  (w_frame_width),
        .i_frame_height (w_frame_height),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_colour       (i_colour),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_colour (o_pixel_colour),
        .o_visible      (o_visible),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bresenham_line_rasterizer
// Drives line commands through the valid/ready command channel, recomputes
// every pixel of each line in a scoreboard and checks the pixel stream field
// by field. Frame width and height go through several settings, including
// zero, the largest register values and an index that wraps. Sender and
// receiver idle in varying patterns.
// ----------------------------------------------------------------------------
module tb;
    import brl_pkg::*;

    localparam int ITEMS_PER_PHASE = 43;
    localparam int NUM_PHASES      = 10;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef struct {
        bit [COORD_W-1:0]  start_x;
        bit [COORD_W-1:0]  start_y;
        bit [COORD_W-1:0]  end_x;
        bit [COORD_W-1:0]  end_y;
        bit [COLOUR_W-1:0] colour;
    } t_line_cmd;

    typedef struct {
        bit [COORD_W-1:0]  x;
        bit [COORD_W-1:0]  y;
        bit [INDEX_W-1:0]  index;
        bit [COLOUR_W-1:0] colour;
        bit                visible;
        bit                last;
    } t_pixel;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    // Expected pixel stream, rebuilt from each accepted line command
    class line_board;
        bit [DIM_W-1:0] frame_width;
        bit [DIM_W-1:0] frame_height;
        t_pixel         expected_pixels[$];
        int             fail_count;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            fail_count   = 0;
        endfunction

        function void write_reg(logic reg_sel, bit [DIM_W-1:0] value);
            if (reg_sel == REG_FRAME_WIDTH) begin
                frame_width = value;
            end else begin
                frame_height = value;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void push_pixel(int x, int y, bit [COLOUR_W-1:0] colour);
            t_pixel p;
            p.x       = COORD_W'(x);
            p.y       = COORD_W'(y);
            p.index   = INDEX_W'(y * int'(frame_width) + x);
            p.colour  = colour;
            p.visible = (x < int'(frame_width)) && (y < int'(frame_height));
            p.last    = 1'b0;
            expected_pixels.push_back(p);
        endfunction

        // Walk the line the same way the block does and queue its pixels
        function void note_command(t_line_cmd c);
            int x0, y0, x1, y1, dx, dy, adx, ady;
            int lo, hi, t, i, step, err, minor;
            bit vertical;
            x0 = int'(c.start_x);
            y0 = int'(c.start_y);
            x1 = int'(c.end_x);
            y1 = int'(c.end_y);
            if (x0 > TILE_SIZE - 1) x0 = TILE_SIZE - 1;
            if (y0 > TILE_SIZE - 1) y0 = TILE_SIZE - 1;
            if (x1 > TILE_SIZE - 1) x1 = TILE_SIZE - 1;
            if (y1 > TILE_SIZE - 1) y1 = TILE_SIZE - 1;
            dx  = x1 - x0;
            dy  = y1 - y0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (dx == 0 || dy == 0) begin
                // straight run from the smaller to the larger coordinate
                vertical = (dx == 0);
                lo = vertical ? y0 : x0;
                hi = vertical ? y1 : x1;
                if (lo > hi) begin
                    t = lo; lo = hi; hi = t;
                end
                for (i = lo; i <= hi; i++) begin
                    if (vertical) push_pixel(x0, i, c.colour);
                    else          push_pixel(i, y0, c.colour);
                end
            end else if (adx > ady) begin
                // x major: order so x increases
                if (x0 > x1) begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                step  = (y1 < y0) ? -1 : 1;
                err   = 2 * ady - adx;
                minor = y0;
                for (i = x0; i <= x1; i++) begin
                    push_pixel(i, minor, c.colour);
                    if (err > 0) begin
                        minor += step;
                        err   -= 2 * adx;
                    end
                    err += 2 * ady;
                end
            end else begin
                // y major, also taken on ties
                if (y0 > y1) begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                step  = (x1 < x0) ? -1 : 1;
                err   = 2 * adx - ady;
                minor = x0;
                for (i = y0; i <= y1; i++) begin
                    push_pixel(minor, i, c.colour);
                    if (err > 0) begin
                        minor += step;
                        err   -= 2 * ady;
                    end
                    err += 2 * adx;
                end
            end
            expected_pixels[$].last = 1'b1;
        endfunction

        function void compare_field(string name, bit [31:0] want, bit [31:0] got);
            if (want !== got) begin
                $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                $display("%0t unexpected pixel x=%0d y=%0d: nothing expected",
                         $time, got.x, got.y);
                fail_count++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pixel_x", 32'(want.x), 32'(got.x));
            compare_field("pixel_y", 32'(want.y), 32'(got.y));
            compare_field("pixel_index", 32'(want.index), 32'(got.index));
            compare_field("pixel_colour", want.colour, got.colour);
            compare_field("visible", 32'(want.visible), 32'(got.visible));
            compare_field("last_pixel", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid   = 1'b0;
    logic                  o_ready;
    logic [COORD_W-1:0]    i_start_x = '0;
    logic [COORD_W-1:0]    i_start_y = '0;
    logic [COORD_W-1:0]    i_end_x   = '0;
    logic [COORD_W-1:0]    i_end_y   = '0;
    logic [COLOUR_W-1:0]   i_colour  = '0;
    logic                  o_valid;
    logic                  i_ready   = 1'b0;
    logic [COORD_W-1:0]    o_pixel_x;
    logic [COORD_W-1:0]    o_pixel_y;
    logic [INDEX_W-1:0]    o_pixel_index;
    logic [COLOUR_W-1:0]   o_pixel_colour;
    logic                  o_visible;
    logic                  o_last_pixel;

    line_board board;
    t_rx_mode  rx_mode     = RX_ALWAYS;
    bit        gaps_on     = 1'b0;
    int        cycle_count = 0;
    t_pixel    seen_pixel;

    bresenham_line_rasterizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_colour       (i_colour),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_colour (o_pixel_colour),
        .o_visible      (o_visible),
        .o_last_pixel   (o_last_pixel)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check each pixel transaction, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_pixel.x       = o_pixel_x;
            seen_pixel.y       = o_pixel_y;
            seen_pixel.index   = o_pixel_index;
            seen_pixel.colour  = o_pixel_colour;
            seen_pixel.visible = o_visible;
            seen_pixel.last    = o_last_pixel;
            board.check_pixel(seen_pixel);
        end
        case (rx_mode)
            RX_ALWAYS:   i_ready <= 1'b1;
            RX_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_ready <= ((cycle_count % 7) < 4);
            default:     i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic t_line_cmd make_line(int sx, int sy, int ex, int ey,
                                            bit [COLOUR_W-1:0] colour);
        t_line_cmd c;
        c.start_x = COORD_W'(sx);
        c.start_y = COORD_W'(sy);
        c.end_x   = COORD_W'(ex);
        c.end_y   = COORD_W'(ey);
        c.colour  = colour;
        return c;
    endfunction

    function automatic int near_coord(int base);
        int v;
        v = base + $urandom_range(0, 14) - 7;
        if (v < 0)  v = 0;
        if (v > 63) v = 63;
        return v;
    endfunction

    // Mix of line shapes: points, runs, diagonals, short and long lines
    function automatic t_line_cmd random_line();
        t_line_cmd c;
        int kind, d, sx, sy, ex, ey, t;
        kind = $urandom_range(0, 9);
        sx = $urandom_range(0, 63);
        sy = $urandom_range(0, 63);
        ex = $urandom_range(0, 63);
        ey = $urandom_range(0, 63);
        case (kind)
            0: begin
                ex = sx;
                ey = sy;
            end
            1: ey = sy;
            2: ex = sx;
            3: begin
                d  = $urandom_range(0, 63);
                sx = $urandom_range(0, 63 - d);
                sy = $urandom_range(0, 63 - d);
                ex = sx + d;
                ey = sy + d;
                if ($urandom_range(0, 1)) begin
                    t = sx; sx = ex; ex = t;
                end
                if ($urandom_range(0, 1)) begin
                    t = sy; sy = ey; ey = t;
                end
            end
            4, 5: begin
                ex = near_coord(sx);
                ey = near_coord(sy);
            end
            default: ;
        endcase
        c = make_line(sx, sy, ex, ey, $urandom);
        return c;
    endfunction

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Present one command and hold it until the transaction completes
    task automatic send_line(t_line_cmd c);
        i_valid   <= 1'b1;
        i_start_x <= c.start_x;
        i_start_y <= c.start_y;
        i_end_x   <= c.end_x;
        i_end_y   <= c.end_y;
        i_colour  <= c.colour;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_command(c);
    endtask

    // Random commands in bursts, with gaps between bursts when enabled
    task automatic send_lines(int count);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if (gaps_on) pause_sender($urandom_range(0, 6));
            end
            send_line(random_line());
            burst_left--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup then access phase; the register takes the value at the access edge
    task automatic write_reg(logic reg_sel, bit [DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({reg_sel, 2'b00});
        pwdata  <= {(APB_DATA_W - DIM_W)'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(reg_sel, value);
    endtask

    initial begin
        t_line_cmd      directed[$];
        bit [DIM_W-1:0] widths[NUM_PHASES];
        bit [DIM_W-1:0] heights[NUM_PHASES];

        board = new();
        widths  = '{7'd1, 7'd0, 7'd127, 7'd33, 7'd64, 7'd1, 7'd100, 7'd7, 7'd0, 7'd0};
        heights = '{7'd1, 7'd0, 7'd127, 7'd17, 7'd1, 7'd64, 7'd20, 7'd63, 7'd0, 7'd0};
        widths[8]  = DIM_W'($urandom_range(0, 127));
        heights[8] = DIM_W'($urandom_range(0, 127));
        widths[9]  = DIM_W'($urandom_range(1, 64));
        heights[9] = DIM_W'($urandom_range(1, 64));

        // Hold reset, then release
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines at the reset frame size
        directed.push_back(make_line(0, 0, 0, 0, 32'h0000_0000));
        directed.push_back(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
        directed.push_back(make_line(0, 0, 63, 0, 32'h5555_5555));
        directed.push_back(make_line(63, 63, 0, 63, 32'hAAAA_AAAA));
        directed.push_back(make_line(63, 0, 63, 63, 32'hFF00_00FF));
        directed.push_back(make_line(0, 63, 0, 0, 32'h00FF_FF00));
        directed.push_back(make_line(0, 0, 63, 63, 32'h8000_0001));
        directed.push_back(make_line(63, 0, 0, 63, 32'h7FFF_FFFE));
        directed.push_back(make_line(63, 63, 0, 0, 32'h1234_5678));
        directed.push_back(make_line(0, 0, 63, 10, 32'hDEAD_BEEF));
        directed.push_back(make_line(63, 10, 0, 0, 32'hCAFE_F00D));
        directed.push_back(make_line(0, 40, 50, 5, 32'h0F0F_0F0F));
        directed.push_back(make_line(5, 0, 9, 63, 32'hF0F0_F0F0));
        directed.push_back(make_line(40, 60, 2, 3, 32'h0000_00FF));
        directed.push_back(make_line(10, 10, 11, 12, 32'hFF00_0000));
        directed.push_back(make_line(10, 10, 12, 11, 32'h00FF_0000));
        directed.push_back(make_line(20, 20, 21, 21, 32'h0000_FF00));
        directed.push_back(make_line(30, 31, 31, 30, 32'h0102_0408));
        directed.push_back(make_line(62, 1, 63, 1, 32'h8040_2010));
        rx_mode = RX_ALWAYS;
        foreach (directed[i]) begin
            pause_sender($urandom_range(0, 2));
            send_line(directed[i]);
        end
        i_valid <= 1'b0;
        wait_for_drain();

        // Random phases, each under its own frame size and stall pattern
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase % 2 == 0) begin
                write_reg(REG_FRAME_WIDTH, widths[phase]);
                write_reg(REG_FRAME_HEIGHT, heights[phase]);
            end else begin
                write_reg(REG_FRAME_HEIGHT, heights[phase]);
                write_reg(REG_FRAME_WIDTH, widths[phase]);
            end
            rx_mode = t_rx_mode'(phase % 4);
            gaps_on = (phase % 3 != 0);
            send_lines(ITEMS_PER_PHASE);
            wait_for_drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
